// ===== hw/rtl/ddw_pkg.sv =====
// Shared types, constants and calendar tables for the date difference block.
package ddw_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int WDAY_W   = 3;
   localparam int SERIAL_W = 23;
   localparam int DIFF_W   = 23;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 14;

   // Year shift that keeps every quotient non-negative
   localparam logic [14:0] YEAR_SHIFT = 15'd399;
   // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT, exact for x < 2^15
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;
   // Whole number of weeks that keeps the weekday sum positive
   localparam logic [24:0] WEEK_OFFSET = 25'd7340032;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REF_YEAR    = 4'd0,
      CSR_REF_MONTH   = 4'd1,
      CSR_REF_DAY     = 4'd2,
      CSR_REF_WEEKDAY = 4'd3
   } csr_index_type;

   typedef struct packed {
      logic a;
      logic b;
      logic c;
   } serial_adv_type;

   function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
      logic [8:0] n;
      case (m)
         4'd1:    n = 9'd0;
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

endpackage

// ===== hw/rtl/ddw_serial.sv =====
// Three-stage pipelined day number of a Gregorian date.
module ddw_serial (
   input  logic                           clock,
   input  ddw_pkg::serial_adv_type        adv,
   input  logic [ddw_pkg::YEAR_W-1:0]     year,
   input  logic [ddw_pkg::MONTH_W-1:0]    month,
   input  logic [ddw_pkg::DAY_W-1:0]      day,
   output logic [ddw_pkg::SERIAL_W-1:0]   serial
);
   import ddw_pkg::*;

   logic [YEAR_W-1:0]  year_a_ff, year_a_in;
   logic [14:0]        py_a_ff, py_a_in;
   logic [MONTH_W-1:0] month_a_ff, month_a_in;
   logic [DAY_W-1:0]   day_a_ff;
   logic [27:0]        prod_py_a_ff, prod_py_a_in;
   logic [26:0]        prod_y_a_ff, prod_y_a_in;

   logic [SERIAL_W-1:0] base_b_ff, base_b_in;
   logic [8:0]          extra_b_ff, extra_b_in;
   logic [SERIAL_W-1:0] serial_c_ff, serial_c_in;

   logic [8:0]        q100_p;
   logic [6:0]        q400_p;
   logic [7:0]        q100_y;
   logic [YEAR_W-1:0] rem100_y;
   logic              leap;

   // stage A: clamp month, shift year, reciprocal products
   always_comb begin
      year_a_in = year;
      py_a_in   = {1'b0, year} + YEAR_SHIFT;
      if (month == 4'd0) begin
         month_a_in = 4'd1;
      end else if (month > 4'd12) begin
         month_a_in = 4'd12;
      end else begin
         month_a_in = month;
      end
      prod_py_a_in = 28'(py_a_in) * 28'(RECIP_100);
      prod_y_a_in  = 27'(year) * 27'(RECIP_100);
   end

   // stage B: century terms, leap rule, month offset
   always_comb begin
      q100_p   = prod_py_a_ff[RECIP_SHIFT +: 9];
      q400_p   = q100_p[8:2];
      q100_y   = prod_y_a_ff[RECIP_SHIFT +: 8];
      rem100_y = year_a_ff - YEAR_W'(q100_y) * YEAR_W'(100);
      leap     = (year_a_ff[1:0] == 2'b00) && ((rem100_y != '0) || (q100_y[1:0] == 2'b00));
      base_b_in = SERIAL_W'(py_a_ff) * SERIAL_W'(365) + SERIAL_W'(py_a_ff[14:2])
                  + SERIAL_W'(q400_p) - SERIAL_W'(q100_p);
      extra_b_in = days_before_month(month_a_ff) + 9'(day_a_ff)
                   + 9'((month_a_ff > 4'd2) && leap);
   end

   // stage C: final sum
   assign serial_c_in = base_b_ff + SERIAL_W'(extra_b_ff);

   always_ff @(posedge clock) begin
      if (adv.a) begin
         year_a_ff    <= year_a_in;
         py_a_ff      <= py_a_in;
         month_a_ff   <= month_a_in;
         day_a_ff     <= day;
         prod_py_a_ff <= prod_py_a_in;
         prod_y_a_ff  <= prod_y_a_in;
      end
      if (adv.b) begin
         base_b_ff  <= base_b_in;
         extra_b_ff <= extra_b_in;
      end
      if (adv.c) begin
         serial_c_ff <= serial_c_in;
      end
   end

   assign serial = serial_c_ff;

endmodule

// ===== hw/rtl/date_difference_and_weekday.sv =====
// A request passes serial stages A, B and C, then stage D and output stage E, to result valid.
// Throughput: one request per cycle while rsp_stall is low; each stage holds only while its successor is full.
// Three day-number pipelines (first, second, reference date), then difference, then mod 7.
// Synchronous active-high reset clears the valid bits and loads the reference
// date registers with 2023-01-01, Sunday.
module date_difference_and_weekday (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ddw_pkg::YEAR_W-1:0]        req_first_year,
   input  logic [ddw_pkg::MONTH_W-1:0]       req_first_month,
   input  logic [ddw_pkg::DAY_W-1:0]         req_first_day,
   input  logic [ddw_pkg::YEAR_W-1:0]        req_second_year,
   input  logic [ddw_pkg::MONTH_W-1:0]       req_second_month,
   input  logic [ddw_pkg::DAY_W-1:0]         req_second_day,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [ddw_pkg::DIFF_W-1:0] rsp_day_difference,
   output logic                              rsp_first_is_later,
   output logic [ddw_pkg::WDAY_W-1:0]        rsp_weekday,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ddw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ddw_pkg::CSR_DATA_W-1:0]    csr_data
);
   import ddw_pkg::*;

   logic [YEAR_W-1:0]  ref_year_ff;
   logic [MONTH_W-1:0] ref_month_ff;
   logic [DAY_W-1:0]   ref_day_ff;
   logic [WDAY_W-1:0]  ref_weekday_ff;

   // valid bits of stages 1..5, stage 5 is the output register
   logic [5:1] vld_ff, vld_in;
   logic [5:1] adv;
   serial_adv_type sadv;

   logic [SERIAL_W-1:0] s1, s2, sr;

   logic [WDAY_W-1:0]   wd_a_ff, wd_b_ff, wd_c_ff;
   logic [DIFF_W-1:0]   diff_d_ff;
   logic                later_d_ff, later_d_in;
   logic [23:0]         wsum_d_ff, wsum_d_in;
   logic [23:0]         delta;

   logic [DIFF_W-1:0]   diff_e_ff;
   logic                later_e_ff;
   logic [WDAY_W-1:0]   wday_e_ff, wday_e_in;
   logic [5:0]          fold1;
   logic [3:0]          fold2;
   logic [3:0]          fold3;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_year_ff    <= YEAR_W'(2023);
         ref_month_ff   <= MONTH_W'(1);
         ref_day_ff     <= DAY_W'(1);
         ref_weekday_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_REF_YEAR:    ref_year_ff    <= csr_data[YEAR_W-1:0];
            CSR_REF_MONTH:   ref_month_ff   <= csr_data[MONTH_W-1:0];
            CSR_REF_DAY:     ref_day_ff     <= csr_data[DAY_W-1:0];
            CSR_REF_WEEKDAY: ref_weekday_ff <= csr_data[WDAY_W-1:0];
            default: ;
         endcase
      end
   end

   // per-stage advance: a stage loads when empty or when its successor moves on
   always_comb begin
      adv[5] = !vld_ff[5] || !rsp_stall;
      adv[4] = !vld_ff[4] || adv[5];
      adv[3] = !vld_ff[3] || adv[4];
      adv[2] = !vld_ff[2] || adv[3];
      adv[1] = !vld_ff[1] || adv[2];
      vld_in = vld_ff;
      if (adv[1]) vld_in[1] = req_valid;
      if (adv[2]) vld_in[2] = vld_ff[1];
      if (adv[3]) vld_in[3] = vld_ff[2];
      if (adv[4]) vld_in[4] = vld_ff[3];
      if (adv[5]) vld_in[5] = vld_ff[4];
   end

   assign req_stall = !adv[1];
   assign sadv = '{a: adv[1], b: adv[2], c: adv[3]};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   ddw_serial u_first (
      .clock (clock), .adv (sadv),
      .year (req_first_year), .month (req_first_month), .day (req_first_day),
      .serial (s1)
   );

   ddw_serial u_second (
      .clock (clock), .adv (sadv),
      .year (req_second_year), .month (req_second_month), .day (req_second_day),
      .serial (s2)
   );

   ddw_serial u_ref (
      .clock (clock), .adv (sadv),
      .year (ref_year_ff), .month (ref_month_ff), .day (ref_day_ff),
      .serial (sr)
   );

   // stage D: difference and biased weekday sum
   always_comb begin
      delta      = {1'b0, s2} - {1'b0, s1};
      later_d_in = delta[23];
      wsum_d_in  = 24'({2'b00, s2} + WEEK_OFFSET + 25'(wd_c_ff) - {2'b00, sr});
   end

   // stage E: mod 7 by octal digit folding (8 = 1 mod 7)
   always_comb begin
      fold1 = 6'(wsum_d_ff[2:0]) + 6'(wsum_d_ff[5:3]) + 6'(wsum_d_ff[8:6])
              + 6'(wsum_d_ff[11:9]) + 6'(wsum_d_ff[14:12]) + 6'(wsum_d_ff[17:15])
              + 6'(wsum_d_ff[20:18]) + 6'(wsum_d_ff[23:21]);
      fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
      fold3 = 4'(fold2[2:0]) + 4'(fold2[3]);
      wday_e_in = (fold3 == 4'd7) ? '0 : fold3[2:0];
   end

   always_ff @(posedge clock) begin
      if (adv[1]) wd_a_ff <= (ref_weekday_ff == 3'd7) ? '0 : ref_weekday_ff;
      if (adv[2]) wd_b_ff <= wd_a_ff;
      if (adv[3]) wd_c_ff <= wd_b_ff;
      if (adv[4]) begin
         diff_d_ff  <= delta[DIFF_W-1:0];
         later_d_ff <= later_d_in;
         wsum_d_ff  <= wsum_d_in;
      end
      if (adv[5]) begin
         diff_e_ff  <= diff_d_ff;
         later_e_ff <= later_d_ff;
         wday_e_ff  <= wday_e_in;
      end
   end

   assign rsp_valid          = vld_ff[5];
   assign rsp_day_difference = signed'(diff_e_ff);
   assign rsp_first_is_later = later_e_ff;
   assign rsp_weekday        = wday_e_ff;

   a_weekday_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_weekday != 3'd7))
      else $error("weekday out of range");

   a_empty_front_accepts: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[1] |-> !req_stall)
      else $error("request stalled with empty first stage");

   a_refill_output: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && vld_ff[4]) |=> rsp_valid)
      else $error("output not refilled from stage four");

endmodule

// ===== sim/ddw_checker.sv =====
// Watches the request, result and register channels, predicts each result and compares it.
module ddw_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [ddw_pkg::YEAR_W-1:0]         req_first_year,
   input  logic [ddw_pkg::MONTH_W-1:0]        req_first_month,
   input  logic [ddw_pkg::DAY_W-1:0]          req_first_day,
   input  logic [ddw_pkg::YEAR_W-1:0]         req_second_year,
   input  logic [ddw_pkg::MONTH_W-1:0]        req_second_month,
   input  logic [ddw_pkg::DAY_W-1:0]          req_second_day,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic signed [ddw_pkg::DIFF_W-1:0]  rsp_day_difference,
   input  logic                               rsp_first_is_later,
   input  logic [ddw_pkg::WDAY_W-1:0]         rsp_weekday,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [ddw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ddw_pkg::CSR_DATA_W-1:0]     csr_data,
   output int                                 pending,
   output int                                 errors
);
   import ddw_pkg::*;

   typedef struct packed {
      logic signed [DIFF_W-1:0] span;
      logic                     later;
      logic [WDAY_W-1:0]        wday;
   } span_answer_type;

   localparam longint MONTH_OFFSET [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273,
                                            304, 334};

   logic [YEAR_W-1:0]  anchor_year;
   logic [MONTH_W-1:0] anchor_month;
   logic [DAY_W-1:0]   anchor_day;
   logic [WDAY_W-1:0]  anchor_wday;
   span_answer_type    awaited_spans [$];
   span_answer_type    oldest;
   int                 fail_count;

   function automatic bit is_leap(input longint y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   // Day number with the year shifted by 400 so every quotient stays non-negative
   function automatic longint day_number(input logic [YEAR_W-1:0] year,
                                         input logic [MONTH_W-1:0] month,
                                         input logic [DAY_W-1:0] day);
      longint y;
      longint m;
      longint py;
      longint n;
      y = longint'(year);
      m = longint'(month);
      if (m < 1) m = 1;
      if (m > 12) m = 12;
      py = y + 399;
      n = 365 * py + py / 4 - py / 100 + py / 400 + MONTH_OFFSET[m - 1];
      if (m > 2 && is_leap(y + 400)) n = n + 1;
      return n + longint'(day);
   endfunction

   function automatic span_answer_type predict_span();
      span_answer_type a;
      longint s1;
      longint s2;
      longint sr;
      longint w;
      logic [63:0] delta;
      s1 = day_number(req_first_year, req_first_month, req_first_day);
      s2 = day_number(req_second_year, req_second_month, req_second_day);
      sr = day_number(anchor_year, anchor_month, anchor_day);
      delta = s2 - s1;
      w = (longint'(anchor_wday) + (s2 - sr)) % 7;
      if (w < 0) w = w + 7;
      a.span = delta[DIFF_W-1:0];
      a.later = (s1 > s2);
      a.wday = w[WDAY_W-1:0];
      return a;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         anchor_year = YEAR_W'(2023);
         anchor_month = MONTH_W'(1);
         anchor_day = DAY_W'(1);
         anchor_wday = '0;
         awaited_spans.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_REF_YEAR:    anchor_year = csr_data[YEAR_W-1:0];
               CSR_REF_MONTH:   anchor_month = csr_data[MONTH_W-1:0];
               CSR_REF_DAY:     anchor_day = csr_data[DAY_W-1:0];
               CSR_REF_WEEKDAY: anchor_wday = csr_data[WDAY_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            awaited_spans.push_back(predict_span());
         if (rsp_valid && !rsp_stall) begin
            if (awaited_spans.size() == 0) begin
               $display("%0t: result with no request waiting: diff %0d later %0d weekday %0d",
                        $realtime, rsp_day_difference, rsp_first_is_later, rsp_weekday);
               fail_count++;
            end else begin
               oldest = awaited_spans.pop_front();
               if (rsp_day_difference !== oldest.span) begin
                  $display("%0t: day_difference expected %0d actual %0d",
                           $realtime, oldest.span, rsp_day_difference);
                  fail_count++;
               end
               if (rsp_first_is_later !== oldest.later) begin
                  $display("%0t: first_is_later expected %0d actual %0d",
                           $realtime, oldest.later, rsp_first_is_later);
                  fail_count++;
               end
               if (rsp_weekday !== oldest.wday) begin
                  $display("%0t: weekday expected %0d actual %0d",
                           $realtime, oldest.wday, rsp_weekday);
                  fail_count++;
               end
            end
         end
      end
      pending <= awaited_spans.size();
      errors <= fail_count;
   end

endmodule

// ===== sim/tb_date_difference_and_weekday.sv =====
// Top of the date difference testbench: clock, reset, stimulus, register phases and verdict.
module tb_date_difference_and_weekday;
   import ddw_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 160;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [YEAR_W-1:0]         req_first_year = '0;
   logic [MONTH_W-1:0]        req_first_month = '0;
   logic [DAY_W-1:0]          req_first_day = '0;
   logic [YEAR_W-1:0]         req_second_year = '0;
   logic [MONTH_W-1:0]        req_second_month = '0;
   logic [DAY_W-1:0]          req_second_day = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [DIFF_W-1:0]  rsp_day_difference;
   logic                      rsp_first_is_later;
   logic [WDAY_W-1:0]         rsp_weekday;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_data = '0;

   int pending;
   int errors;
   int cycle_count = 0;
   int stall_left = 0;
   bit noise_on = 1'b1;

   always #5 clock = ~clock;

   date_difference_and_weekday DUT (.*);

   ddw_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset || !noise_on) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 4);
      end
   end

   task automatic send_dates(input int fy, input int fm, input int fd,
                             input int sy, input int sm, input int sd);
      if (noise_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_first_year <= YEAR_W'(fy);
      req_first_month <= MONTH_W'(fm);
      req_first_day <= DAY_W'(fd);
      req_second_year <= YEAR_W'(sy);
      req_second_month <= MONTH_W'(sm);
      req_second_day <= DAY_W'(sd);
      do @(posedge clock); while (req_stall);
   endtask

   // Mostly calendar dates, some in the years 2015 to 2030, the rest any bit pattern
   task automatic send_random_dates();
      int y [2];
      int m [2];
      int d [2];
      int mode;
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 2; i++) begin
         if (mode == 0) begin
            y[i] = $urandom_range(0, 16383);
            m[i] = $urandom_range(0, 15);
            d[i] = $urandom_range(0, 31);
         end else begin
            y[i] = (mode < 4) ? $urandom_range(2015, 2030) : $urandom_range(1, 9999);
            m[i] = $urandom_range(1, 12);
            d[i] = (mode < 7) ? $urandom_range(1, 28) : $urandom_range(1, 31);
         end
      end
      send_dates(y[0], m[0], d[0], y[1], m[1], d[1]);
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_anchor(input int year, input int month, input int day,
                               input int wday, input bit stray);
      logic [CSR_IDX_W-1:0]  idx [5];
      logic [CSR_DATA_W-1:0] val [5];
      int count;
      idx = '{CSR_REF_YEAR, CSR_REF_MONTH, CSR_REF_DAY, CSR_REF_WEEKDAY,
              CSR_REF_WEEKDAY + CSR_IDX_W'($urandom_range(1, 12))};
      val = '{CSR_DATA_W'(year), CSR_DATA_W'(month), CSR_DATA_W'(day), CSR_DATA_W'(wday),
              CSR_DATA_W'($urandom_range(0, 16383))};
      count = stray ? 5 : 4;
      for (int i = 0; i < count; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data <= val[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, leap rules, weeks backward, out-of-range fields, wrap
      send_dates(2023, 1, 1, 2023, 1, 1);
      send_dates(2024, 2, 28, 2024, 3, 1);
      send_dates(1900, 2, 28, 1900, 3, 1);
      send_dates(2000, 2, 28, 2000, 3, 1);
      send_dates(2023, 6, 15, 2023, 3, 10);
      send_dates(1, 1, 1, 9999, 12, 31);
      send_dates(9999, 12, 31, 1, 1, 1);
      send_dates(2023, 1, 1, 2022, 12, 25);
      send_dates(2023, 1, 1, 2022, 12, 31);
      send_dates(2023, 0, 10, 2023, 15, 10);
      send_dates(2023, 13, 1, 2023, 12, 1);
      send_dates(2023, 2, 0, 2023, 2, 31);
      send_dates(0, 3, 1, 0, 2, 29);
      send_dates(16383, 15, 31, 0, 0, 0);
      send_dates(0, 0, 0, 16383, 15, 31);
      send_dates(2023, 12, 31, 2024, 1, 1);
      send_dates(1, 1, 1, 1, 1, 1);
      send_dates(2100, 2, 28, 2100, 3, 1);
      send_dates(2023, 1, 1, 2022, 11, 20);
      req_valid <= 1'b0;
      wait_drained();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_anchor(2023, 1, 1, 0, 1'b0);
            1: write_anchor(1, 1, 1, 1, 1'b1);
            2: write_anchor(9999, 12, 31, 6, 1'b0);
            3: write_anchor(0, 0, 0, 7, 1'b1);
            4: write_anchor(16383, 15, 31, 5, 1'b0);
            default: begin
               noise_on = 1'b0;
               write_anchor($urandom_range(1, 9999), $urandom_range(1, 12),
                            $urandom_range(1, 28), $urandom_range(0, 7), 1'b1);
            end
         endcase
         // reference date itself, then a whole week before it
         if (phase == 2) begin
            send_dates(9999, 12, 31, 9999, 12, 31);
            send_dates(9999, 12, 31, 9999, 12, 24);
         end
         repeat (PHASE_ITEMS) send_random_dates();
         req_valid <= 1'b0;
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
